/* hw/rtl/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg
// Shared types and constants for the mouse packet tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpt_pkg;

    localparam int POS_BITS  = 12;
    localparam int COORD_W   = 12;
    localparam int SIZE_W    = 13;
    localparam int DELTA_W   = 10;
    localparam int LIM_W     = (POS_BITS + 1 > SIZE_W) ? POS_BITS + 1 : SIZE_W;
    localparam int SUM_W     = POS_BITS + 2;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_X_MOVE = 2'd1;
    localparam logic [1:0] IDX_Y_MOVE = 2'd2;
    localparam logic [1:0] IDX_UNUSED = 2'd3;

    localparam int BTN_LEFT_BIT   = 0;
    localparam int BTN_RIGHT_BIT  = 1;
    localparam int BTN_MIDDLE_BIT = 2;
    localparam int SYNC_BIT       = 3;
    localparam int X_SIGN_BIT     = 4;
    localparam int Y_SIGN_BIT     = 5;

    typedef struct packed {
        logic                      done;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy_neg;
        logic                      left;
        logic                      right;
        logic                      middle;
    } pkt_t;

endpackage

`default_nettype wire

/* hw/rtl/mpt_packet_asm.sv */
// ----------------------------------------------------------------------------
// mpt_packet_asm
// Gathers three-byte packets, keeps header sync and decodes the deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_packet_asm
    import mpt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] rx_byte,
    output pkt_t            pkt
);

    logic [1:0] byte_index_reg, byte_index_next;
    logic [7:0] header_reg, header_next;
    logic [7:0] x_move_reg, x_move_next;
    logic       done;

    always_comb begin
        byte_index_next = byte_index_reg;
        header_next     = header_reg;
        x_move_next     = x_move_reg;
        done            = 1'b0;
        unique case (byte_index_reg)
            IDX_X_MOVE: begin
                x_move_next     = rx_byte;
                byte_index_next = IDX_Y_MOVE;
            end
            IDX_Y_MOVE: begin
                byte_index_next = IDX_HEADER;
                done            = 1'b1;
            end
            default: begin
                if (rx_byte[SYNC_BIT]) begin
                    header_next     = rx_byte;
                    byte_index_next = IDX_X_MOVE;
                end else begin
                    byte_index_next = IDX_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= IDX_HEADER;
        end else if (advance) begin
            byte_index_reg <= byte_index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            header_reg <= header_next;
            x_move_reg <= x_move_next;
        end
    end

    // 9-bit two's complement deltas, sign from the header
    logic signed [DELTA_W-1:0] dx_ext;
    logic signed [DELTA_W-1:0] dy_ext;

    assign dx_ext = DELTA_W'($signed({header_reg[X_SIGN_BIT], x_move_reg}));
    assign dy_ext = DELTA_W'($signed({header_reg[Y_SIGN_BIT], rx_byte}));

    assign pkt.done   = done;
    assign pkt.dx     = dx_ext;
    assign pkt.dy_neg = -dy_ext;
    assign pkt.left   = header_reg[BTN_LEFT_BIT];
    assign pkt.right  = header_reg[BTN_RIGHT_BIT];
    assign pkt.middle = header_reg[BTN_MIDDLE_BIT];

`ifndef SYNTHESIS
    a_index_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg != IDX_UNUSED)
        else $error("packet index reached unused code");

    a_header_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_index_reg == IDX_X_MOVE || byte_index_reg == IDX_Y_MOVE)
            |-> header_reg[SYNC_BIT])
        else $error("packet started on header without sync bit");

    a_unsynced_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && byte_index_reg == IDX_HEADER && !rx_byte[SYNC_BIT])
            |=> byte_index_reg == IDX_HEADER)
        else $error("byte without sync bit started a packet");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mpt_axis_clamp.sv */
// ----------------------------------------------------------------------------
// mpt_axis_clamp
// Moves one coordinate by a signed delta and clamps it to the screen size.
// ----------------------------------------------------------------------------
`default_nettype none

module mpt_axis_clamp
    import mpt_pkg::*;
(
    input  wire logic        [POS_BITS-1:0] pos,
    input  wire logic signed [DELTA_W-1:0]  delta,
    input  wire logic        [SIZE_W-1:0]   size,
    output logic             [POS_BITS-1:0] new_pos
);

    localparam logic [LIM_W-1:0] CAP = LIM_W'(1) << POS_BITS;

    logic [LIM_W-1:0]        size_w;
    logic [POS_BITS-1:0]     limit;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] limit_s;

    assign size_w = LIM_W'(size);

    always_comb begin
        if (size_w == '0) begin
            limit = '0;
        end else if (size_w > CAP) begin
            limit = POS_BITS'(CAP - LIM_W'(1));
        end else begin
            limit = POS_BITS'(size_w - LIM_W'(1));
        end
    end

    assign sum     = $signed(SUM_W'(pos)) + SUM_W'(delta);
    assign limit_s = $signed(SUM_W'(limit));

    always_comb begin
        if (sum < 0) begin
            new_pos = '0;
        end else if (sum > limit_s) begin
            new_pos = limit;
        end else begin
            new_pos = POS_BITS'(sum);
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ps2_mouse_packet_tracker_unit.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// Three-byte mouse packet decoder with a clamped cursor position.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  s_axis   | in        | one received mouse byte per transfer
//  m_axis   | out       | cursor position and buttons, one per complete packet
//  cfg      | in        | screen width (index 0) and height (index 1)
//
//  a byte passes through the input register, and a completed packet's result through the result register
//  a byte can be taken every cycle unless held back as below; the position update is a single add and clamp
//  a stalled result only holds back a byte that would complete the next packet
//  reset is synchronous and restores 640 x 480 with the cursor at the origin
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_tracker_unit
    import mpt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // [11:0] cursor_x, [23:12] cursor_y,
                                                  // [24] left_pressed, [25] right_pressed,
                                                  // [26] middle_pressed, [31:27] zero

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SIZE_W-1:0]     cfg_data
);

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [POS_BITS-1:0]   pos_x_reg, pos_x_next;
    logic [POS_BITS-1:0]   pos_y_reg, pos_y_next;
    logic [SIZE_W-1:0]     width_reg, height_reg;

    logic advance;
    pkt_t pkt;

    mpt_packet_asm u_asm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .pkt     (pkt)
    );

    mpt_axis_clamp u_clamp_x (
        .pos     (pos_x_reg),
        .delta   (pkt.dx),
        .size    (width_reg),
        .new_pos (pos_x_next)
    );

    mpt_axis_clamp u_clamp_y (
        .pos     (pos_y_reg),
        .delta   (pkt.dy_neg),
        .size    (height_reg),
        .new_pos (pos_y_next)
    );

    assign advance   = in_valid_reg && (!pkt.done || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (advance && pkt.done) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'b0, pkt.middle, pkt.right, pkt.left,
                              COORD_W'(pos_y_next), COORD_W'(pos_x_next)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance && pkt.done) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SCREEN_WIDTH) begin
                    width_reg <= cfg_data;
                end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
                    height_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_reset_no_result: assert property (@(posedge aclk)
        !aresetn |=> !out_valid_reg)
        else $error("result valid right after reset");

    a_packet_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && pkt.done) |=> out_valid_reg)
        else $error("completed packet produced no result");

    a_result_from_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(advance && pkt.done))
        else $error("result appeared without a completed packet");
`endif

endmodule

`default_nettype wire

/* tb/tb_ps2_mouse_packet_tracker_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker_unit
// Drives mouse bytes into the packet tracker and checks every cursor transfer
// against a cycle-free model of the packet framing, movement and clamping.
// A directed part runs first at the reset screen size. It is followed by phases
// of random packets, noise and broken packets under several screen sizes: the
// smallest, zero, oversized, the largest and random ones. Sender gaps and
// receiver stalls vary per phase, and one phase holds the receiver off long
// enough to back up the input.
// ----------------------------------------------------------------------------

module tb_ps2_mouse_packet_tracker_unit
    import mpt_pkg::*;
();

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    typedef enum int {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_e;
    typedef enum int {RX_FREE, RX_COIN, RX_PATTERN} rx_mode_e;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               left;
        logic               right;
        logic               middle;
    } cursor_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [SIZE_W-1:0]     cfg_data = '0;

    // pending mouse bytes and expected cursor transfers
    logic [7:0] byte_q[$];
    cursor_t    cursor_q[$];

    // tracker model state
    logic [1:0]          pkt_slot = IDX_HEADER;
    logic [7:0]          hdr_byte = '0;
    logic [7:0]          move_x = '0;
    logic [POS_BITS-1:0] pos_x = '0;
    logic [POS_BITS-1:0] pos_y = '0;
    logic [SIZE_W-1:0]   width_cfg = WIDTH_RESET;
    logic [SIZE_W-1:0]   height_cfg = HEIGHT_RESET;

    int       n_fail = 0;
    int       quiet_cycles = 0;
    bit       sender_gaps = 1'b0;
    int       burst_cnt = 0;
    int       gap_cnt = 0;
    bit       drv_go;
    rx_mode_e rx_mode = RX_FREE;
    int       rx_hold_reqs = 0;
    int       rx_hold_seen = 0;
    int       hold_left = 0;
    logic [7:0] rx_pat = 8'hff;
    int       pat_cnt = 0;

    ps2_mouse_packet_tracker_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [POS_BITS-1:0] clamp_coord(int v, logic [SIZE_W-1:0] size);
        int top;
        if (size == 0)
            top = 0;
        else if (int'(size) > (1 << POS_BITS))
            top = (1 << POS_BITS) - 1;
        else
            top = int'(size) - 1;
        if (v < 0)
            v = 0;
        if (v > top)
            v = top;
        return v[POS_BITS-1:0];
    endfunction

    // frame one byte and, on a completed packet, move the cursor
    task automatic track_byte(input logic [7:0] b);
        int      dx;
        int      dy;
        cursor_t c;
        case (pkt_slot)
            IDX_X_MOVE: begin
                move_x = b;
                pkt_slot = IDX_Y_MOVE;
            end
            IDX_Y_MOVE: begin
                pkt_slot = IDX_HEADER;
                dx = int'(move_x) - (hdr_byte[X_SIGN_BIT] ? 256 : 0);
                dy = int'(b) - (hdr_byte[Y_SIGN_BIT] ? 256 : 0);
                pos_x = clamp_coord(int'(pos_x) + dx, width_cfg);
                pos_y = clamp_coord(int'(pos_y) - dy, height_cfg);
                c.cx = pos_x[COORD_W-1:0];
                c.cy = pos_y[COORD_W-1:0];
                c.left = hdr_byte[BTN_LEFT_BIT];
                c.right = hdr_byte[BTN_RIGHT_BIT];
                c.middle = hdr_byte[BTN_MIDDLE_BIT];
                cursor_q.push_back(c);
            end
            default: begin
                if (b[SYNC_BIT]) begin
                    hdr_byte = b;
                    pkt_slot = IDX_X_MOVE;
                end else begin
                    pkt_slot = IDX_HEADER;
                end
            end
        endcase
    endtask

    // byte driver: bursts with random gaps when sender gaps are enabled
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                drv_go = 1'b0;
                if (gap_cnt != 0) begin
                    gap_cnt--;
                end else if (byte_q.size() != 0) begin
                    s_tdata <= byte_q.pop_front();
                    drv_go = 1'b1;
                    if (burst_cnt != 0) begin
                        burst_cnt--;
                    end else begin
                        burst_cnt = $urandom_range(0, 24);
                        gap_cnt = sender_gaps ? $urandom_range(1, 8) : 0;
                    end
                end
                s_tvalid <= drv_go;
            end
        end
    end

    // cursor receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_FREE: begin
                    m_tready <= 1'b1;
                end
                RX_COIN: begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    pat_cnt++;
                    if (pat_cnt == 64) begin
                        pat_cnt = 0;
                        rx_pat = 8'($urandom) | 8'h01;
                    end else begin
                        rx_pat = {rx_pat[0], rx_pat[7:1]};
                    end
                    m_tready <= rx_pat[0];
                end
            endcase
        end
    end

    // cursor monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (cursor_q.size() == 0) begin
                $error("cursor transfer with none expected: tdata %h", m_tdata);
                n_fail++;
            end else begin
                if (m_tdata[11:0] !== cursor_q[0].cx) begin
                    $error("cursor_x: expected %0d, got %0d", cursor_q[0].cx, m_tdata[11:0]);
                    n_fail++;
                end
                if (m_tdata[23:12] !== cursor_q[0].cy) begin
                    $error("cursor_y: expected %0d, got %0d", cursor_q[0].cy, m_tdata[23:12]);
                    n_fail++;
                end
                if (m_tdata[24] !== cursor_q[0].left) begin
                    $error("left_pressed: expected %0b, got %0b", cursor_q[0].left, m_tdata[24]);
                    n_fail++;
                end
                if (m_tdata[25] !== cursor_q[0].right) begin
                    $error("right_pressed: expected %0b, got %0b",
                           cursor_q[0].right, m_tdata[25]);
                    n_fail++;
                end
                if (m_tdata[26] !== cursor_q[0].middle) begin
                    $error("middle_pressed: expected %0b, got %0b",
                           cursor_q[0].middle, m_tdata[26]);
                    n_fail++;
                end
                void'(cursor_q.pop_front());
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH)
            width_cfg = val;
        else if (idx == CFG_SCREEN_HEIGHT)
            height_cfg = val;
        @(posedge aclk);
    endtask

    task automatic wait_drain();
        do @(posedge aclk); while (byte_q.size() != 0 || s_tvalid || cursor_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_packet(input drift_e drift);
        logic [7:0] hdr;
        logic [7:0] xb;
        logic [7:0] yb;
        hdr = 8'($urandom);
        hdr[SYNC_BIT] = 1'b1;
        xb = 8'($urandom);
        yb = 8'($urandom);
        if (drift == DRIFT_UP) begin
            hdr[X_SIGN_BIT] = 1'b0;
            xb = 8'($urandom_range(128, 255));
            hdr[Y_SIGN_BIT] = 1'b1;
            yb = 8'($urandom_range(0, 127));
        end else if (drift == DRIFT_DOWN) begin
            hdr[X_SIGN_BIT] = 1'b1;
            xb = 8'($urandom_range(0, 127));
            hdr[Y_SIGN_BIT] = 1'b0;
            yb = 8'($urandom_range(128, 255));
        end
        byte_q.push_back(hdr);
        byte_q.push_back(xb);
        byte_q.push_back(yb);
    endtask

    // mostly whole packets, some noise and some cut-off packets
    task automatic fill_random(input int n, input drift_e drift);
        int added;
        int r;
        logic [7:0] hdr;
        added = 0;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                push_packet(drift);
                added += 3;
            end else if (r < 90) begin
                byte_q.push_back(8'($urandom));
                added++;
            end else begin
                hdr = 8'($urandom);
                hdr[SYNC_BIT] = 1'b1;
                byte_q.push_back(hdr);
                byte_q.push_back(8'($urandom));
                added += 2;
            end
        end
    endtask

    task automatic run_phase(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input drift_e drift, input int n, input bit gaps,
                             input rx_mode_e rxm, input bit hold);
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        sender_gaps <= gaps;
        rx_mode <= rxm;
        if (hold)
            rx_hold_reqs <= rx_hold_reqs + 1;
        fill_random(n, drift);
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at the reset screen size
        sender_gaps <= 1'b1;
        rx_mode <= RX_COIN;
        byte_q = '{8'h00, 8'hf7,
                   8'h08, 8'h00, 8'h00,
                   8'h2f, 8'hff, 8'h80,
                   8'h3f, 8'h00, 8'h00,
                   8'h29, 8'hff, 8'h00,
                   8'h08, 8'hff, 8'h08,
                   8'h08, 8'hff, 8'h00,
                   8'h18, 8'h01, 8'h7f,
                   8'hff, 8'hff, 8'hff};
        wait_drain();

        run_phase(13'd1, 13'd1, DRIFT_NONE, 60, 1'b1, RX_PATTERN, 1'b0);
        run_phase(13'd0, 13'd0, DRIFT_UP, 60, 1'b0, RX_FREE, 1'b0);
        run_phase(13'd8191, 13'd4097, DRIFT_UP, 150, 1'b1, RX_COIN, 1'b0);
        write_reg(CFG_LAST_UNUSED, 13'd8191);
        write_reg(CFG_FIRST_UNUSED, 13'd0);
        run_phase(13'd4096, 13'd4096, DRIFT_DOWN, 150, 1'b1, RX_PATTERN, 1'b0);
        run_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), DRIFT_NONE,
                  150, 1'b0, RX_COIN, 1'b1);
        run_phase(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)),
                  drift_e'($urandom_range(0, 2)), 150, 1'b1, RX_FREE, 1'b0);
        run_phase(13'd640, 13'd480, DRIFT_NONE, 200, 1'b1, RX_PATTERN, 1'b0);

        repeat (10) @(posedge aclk);
        if (cursor_q.size() != 0) begin
            $error("%0d cursor transfers never arrived", cursor_q.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mpt_pkg.sv
hw/rtl/mpt_packet_asm.sv
hw/rtl/mpt_axis_clamp.sv
hw/rtl/ps2_mouse_packet_tracker_unit.sv
tb/tb_ps2_mouse_packet_tracker_unit.sv
